// ===== rtl/core/seven_segment_serial_writer_unit_assert.svh =====
// Assertion macros for the seven-segment serial writer checker.
// Sampled on clk, disabled while rst_n is low; no other dependencies.
`ifndef SEVEN_SEGMENT_SERIAL_WRITER_UNIT_ASSERT_SVH
`define SEVEN_SEGMENT_SERIAL_WRITER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SVSW_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svsw assertion failed");

// Next-cycle implication.
`define SVSW_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svsw assertion failed");

`endif

// ===== rtl/core/svsw_pkg.sv =====
// Shared types, constants and the segment table for the serial writer.
// No dependencies.
package svsw_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CMD_FIXED_ADDR = 8'h44;
    localparam logic [7:0] CMD_ADDR_BASE  = 8'hC0;
    localparam logic [7:0] CMD_DISPLAY_ON = 8'h88;
    localparam logic [7:0] SEG_BLANK      = 8'h00;

    // configuration register indexes
    localparam logic CFG_BRIGHTNESS = 1'b0;
    localparam logic CFG_TICKS      = 1'b1;

    typedef struct packed {
        logic       req;
        logic [1:0] pos;
        logic [7:0] seg;
        logic       dio_in;
    } svsw_item_t;

    typedef struct packed {
        logic [2:0] brightness;
        logic [7:0] ticks_per_unit;
    } svsw_cfg_t;

    // hex digits, digits with point, then blank
    function automatic logic [7:0] seg_lookup(input logic [4:0] code);
        logic [7:0] s;
        case (code)
            5'd0:  s = 8'h3F;
            5'd1:  s = 8'h06;
            5'd2:  s = 8'h5B;
            5'd3:  s = 8'h4F;
            5'd4:  s = 8'h66;
            5'd5:  s = 8'h6D;
            5'd6:  s = 8'h7D;
            5'd7:  s = 8'h07;
            5'd8:  s = 8'h7F;
            5'd9:  s = 8'h6F;
            5'd10: s = 8'h77;
            5'd11: s = 8'h7C;
            5'd12: s = 8'h39;
            5'd13: s = 8'h5E;
            5'd14: s = 8'h79;
            5'd15: s = 8'h71;
            5'd16: s = 8'hBF;
            5'd17: s = 8'h86;
            5'd18: s = 8'hDB;
            5'd19: s = 8'hCF;
            5'd20: s = 8'hE6;
            5'd21: s = 8'hED;
            5'd22: s = 8'hFD;
            5'd23: s = 8'h87;
            5'd24: s = 8'hFF;
            5'd25: s = 8'hEF;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/core/svsw_front.sv =====
// Front end: unpacks an incoming tick and classifies its show request.
// Depends on svsw_pkg.
module svsw_front
    import svsw_pkg::*;
#(
    parameter int DIGITS = 4
)
(
    input  logic       tuser,    // cmd
    input  logic [7:0] tdata,    // digit_position[1:0], digit_code[6:2], dio_in[7]
    output svsw_item_t item
);

    localparam logic [2:0] DIGIT_LIMIT = 3'(DIGITS);

    logic [1:0] pos;
    logic [4:0] code;

    assign pos  = tdata[1:0];
    assign code = tdata[6:2];

    always_comb
    begin
        item.req    = tuser && ({1'b0, pos} < DIGIT_LIMIT);
        item.pos    = pos;
        item.seg    = seg_lookup(code);
        item.dio_in = tdata[7];
    end

endmodule

// ===== rtl/core/svsw_queue.sv =====
// Short request queue between the front end and the sequencer.
// Depends on svsw_pkg.
module svsw_queue
    import svsw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  svsw_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output svsw_item_t out_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    svsw_item_t       slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_FULL);
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/core/svsw_seq.sv =====
// Back end: the frame sequencer, one step per queued tick, with output register.
// Depends on svsw_pkg.
module svsw_seq
    import svsw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  svsw_cfg_t  cfg,
    input  logic       q_valid,
    output logic       q_ready,
    input  svsw_item_t q_item,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata
);

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_ST_HI    = 4'd1;
    localparam logic [3:0] PH_ST_LO    = 4'd2;
    localparam logic [3:0] PH_BIT_LO   = 4'd3;
    localparam logic [3:0] PH_BIT_HI   = 4'd4;
    localparam logic [3:0] PH_ACK_LO   = 4'd5;
    localparam logic [3:0] PH_ACK_WAIT = 4'd6;
    localparam logic [3:0] PH_ACK_HI   = 4'd7;
    localparam logic [3:0] PH_SP_LO    = 4'd8;
    localparam logic [3:0] PH_SP_D0    = 4'd9;
    localparam logic [3:0] PH_SP_HI    = 4'd10;
    localparam logic [3:0] PH_SP_D1    = 4'd11;

    localparam logic [1:0] FR_CMD  = 2'd0;
    localparam logic [1:0] FR_ADDR = 2'd1;
    localparam logic [1:0] FR_SEG  = 2'd2;
    localparam logic [1:0] FR_CTRL = 2'd3;

    typedef struct packed {
        logic [3:0]  phase;
        logic [1:0]  frame;
        logic [2:0]  bits;
        logic [7:0]  shifter;
        logic [10:0] delay;
        logic        clk_lv;
        logic        dio_lv;
    } seq_state_t;

    typedef struct packed {
        logic [1:0]  lat_pos;
        logic [7:0]  lat_seg;
        logic [2:0]  bright;
        logic [10:0] d2;
        logic [10:0] d3;
        logic [10:0] d5;
    } seq_ctx_t;

    localparam seq_state_t ST_RESET = '{phase: PH_IDLE, frame: FR_CMD, bits: 3'd0,
                                        shifter: 8'd0, delay: 11'd0, clk_lv: 1'b1,
                                        dio_lv: 1'b1};

    function automatic logic [7:0] frame_byte(input logic [1:0] fr, input seq_ctx_t c);
        logic [7:0] b;
        case (fr)
            FR_CMD:  b = CMD_FIXED_ADDR;
            FR_ADDR: b = CMD_ADDR_BASE + {6'b0, c.lat_pos};
            FR_SEG:  b = c.lat_seg;
            default: b = CMD_DISPLAY_ON | {5'b0, c.bright};
        endcase
        return b;
    endfunction

    // pins are set on entry, the wait is loaded from the phase's unit count or is one tick
    function automatic seq_state_t enter_phase(input seq_state_t s, input logic [3:0] p,
                                               input seq_ctx_t c);
        seq_state_t r;
        r       = s;
        r.phase = p;
        r.delay = 11'd1;
        case (p)
            PH_ST_HI:
            begin
                r.clk_lv  = 1'b1;
                r.dio_lv  = 1'b1;
                r.shifter = frame_byte(s.frame, c);
            end
            PH_ST_LO:
            begin
                r.dio_lv = 1'b0;
                r.delay  = c.d3;
            end
            PH_BIT_LO:
            begin
                r.clk_lv = 1'b0;
                r.dio_lv = s.shifter[0];
                r.delay  = c.d3;
            end
            PH_BIT_HI:
            begin
                r.clk_lv = 1'b1;
                r.delay  = c.d3;
            end
            PH_ACK_LO:
            begin
                r.clk_lv = 1'b0;
                r.delay  = c.d5;
            end
            PH_ACK_WAIT:
            begin
                r.delay = 11'd1;
            end
            PH_ACK_HI:
            begin
                r.clk_lv = 1'b1;
                r.delay  = c.d2;
            end
            PH_SP_LO:
            begin
                r.clk_lv = 1'b0;
                r.delay  = c.d3;
            end
            PH_SP_D0:
            begin
                r.dio_lv = 1'b0;
            end
            PH_SP_HI:
            begin
                r.clk_lv = 1'b1;
                r.delay  = c.d3;
            end
            PH_SP_D1:
            begin
                r.dio_lv = 1'b1;
            end
            default:
            begin
                r.clk_lv = 1'b1;
                r.dio_lv = 1'b1;
                r.phase  = PH_IDLE;
            end
        endcase
        return r;
    endfunction

    function automatic seq_state_t advance(input seq_state_t s, input seq_ctx_t c);
        seq_state_t r;
        r = s;
        case (s.phase)
            PH_ST_HI:    r = enter_phase(s, PH_ST_LO, c);
            PH_ST_LO:
            begin
                r.bits = 3'd0;
                r      = enter_phase(r, PH_BIT_LO, c);
            end
            PH_BIT_LO:   r = enter_phase(s, PH_BIT_HI, c);
            PH_BIT_HI:
            begin
                r.shifter = {1'b0, s.shifter[7:1]};
                r.bits    = s.bits + 3'd1;
                r         = enter_phase(r, (r.bits == 3'd0) ? PH_ACK_LO : PH_BIT_LO, c);
            end
            PH_ACK_LO:   r = enter_phase(s, PH_ACK_WAIT, c);
            PH_ACK_WAIT: r = enter_phase(s, PH_ACK_HI, c);
            PH_ACK_HI:
            begin
                // address byte is followed by the segment byte in the same frame
                if (s.frame == FR_ADDR)
                begin
                    r.frame   = FR_SEG;
                    r.shifter = c.lat_seg;
                    r.bits    = 3'd0;
                    r         = enter_phase(r, PH_BIT_LO, c);
                end
                else
                begin
                    r = enter_phase(s, PH_SP_LO, c);
                end
            end
            PH_SP_LO:    r = enter_phase(s, PH_SP_D0, c);
            PH_SP_D0:    r = enter_phase(s, PH_SP_HI, c);
            PH_SP_HI:    r = enter_phase(s, PH_SP_D1, c);
            PH_SP_D1:
            begin
                if (s.frame == FR_CTRL)
                begin
                    r = enter_phase(s, PH_IDLE, c);
                end
                else
                begin
                    r.frame = (s.frame == FR_CMD) ? FR_ADDR : FR_CTRL;
                    r       = enter_phase(r, PH_ST_HI, c);
                end
            end
            default:     r = enter_phase(s, PH_IDLE, c);
        endcase
        return r;
    endfunction

    seq_state_t  st_reg, st_next;
    logic [1:0]  lat_pos_reg, lat_pos_next;
    logic [7:0]  lat_seg_reg, lat_seg_next;
    logic        out_valid_reg;
    logic [7:0]  out_data_reg, out_data_next;
    logic [7:0]  tpu;
    logic [10:0] tpu_x2;
    seq_ctx_t    ctx;
    logic        acc;
    logic        drive;
    logic        pop;

    assign tpu    = (cfg.ticks_per_unit == 8'd0) ? 8'd1 : cfg.ticks_per_unit;
    assign tpu_x2 = {2'b0, tpu, 1'b0};

    always_comb
    begin
        ctx.lat_pos = lat_pos_reg;
        ctx.lat_seg = lat_seg_reg;
        ctx.bright  = cfg.brightness;
        ctx.d2      = tpu_x2;
        ctx.d3      = tpu_x2 + {3'b0, tpu};
        ctx.d5      = {1'b0, tpu, 2'b0} + {3'b0, tpu};
    end

    assign q_ready = !out_valid_reg || m_tready;
    assign pop     = q_valid && q_ready;

    always_comb
    begin
        st_next      = st_reg;
        lat_pos_next = lat_pos_reg;
        lat_seg_next = lat_seg_reg;
        acc          = 1'b0;
        if (st_reg.phase == PH_IDLE)
        begin
            if (q_item.req)
            begin
                acc          = 1'b1;
                lat_pos_next = q_item.pos;
                lat_seg_next = q_item.seg;
                st_next.frame = FR_CMD;
                st_next       = enter_phase(st_next, PH_ST_HI, ctx);
            end
        end
        else if (st_reg.phase == PH_ACK_WAIT)
        begin
            if (!q_item.dio_in)
            begin
                st_next = advance(st_reg, ctx);
            end
        end
        else
        begin
            st_next.delay = st_reg.delay - 11'd1;
            if (st_next.delay == 11'd0)
            begin
                st_next = advance(st_next, ctx);
                // ack already present on the tick the wait expires
                if (st_next.phase == PH_ACK_WAIT && !q_item.dio_in)
                begin
                    st_next = advance(st_next, ctx);
                end
            end
        end

        drive = !(st_next.phase == PH_ACK_LO || st_next.phase == PH_ACK_WAIT ||
                  st_next.phase == PH_ACK_HI || st_next.phase == PH_SP_LO);
        out_data_next = {3'b0, acc, (st_next.phase != PH_IDLE), drive,
                         (drive ? st_next.dio_lv : 1'b1), st_next.clk_lv};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= ST_RESET;
            lat_pos_reg    <= '0;
            lat_seg_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                st_reg      <= st_next;
                lat_pos_reg <= lat_pos_next;
                lat_seg_reg <= lat_seg_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/core/seven_segment_serial_writer_unit.sv =====
// Two-wire seven-segment display writer: each input request is one tick of time. A tick
// carrying a show request while idle starts three frames (fixed-address command, address
// plus segments, display-on with brightness) that are bit-banged on the clock and data pin
// levels reported in each result; every tick gives exactly one result. One tick is taken
// per clock cycle unless a held result stalls the sequencer, which does one step per tick;
// a two-entry queue sits between the input classifier and the sequencer, and a result
// register sits on the output; a request passes a queue slot, then the result register.
// Delays are units times ticks_per_unit ticks, not clock cycles.
// Depends on svsw_pkg, svsw_front, svsw_queue and svsw_seq.
module seven_segment_serial_writer_unit
    import svsw_pkg::*;
#(
    parameter int DIGITS = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // digit_position[1:0], digit_code[6:2], dio_in[7]
    input  logic       s_tuser,    // cmd
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // clk_pin, dio_pin, dio_drive, busy_res, accepted, zeros
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata
);

    svsw_item_t front_item;
    svsw_item_t q_item;
    logic       q_valid;
    logic       q_ready;
    svsw_cfg_t  cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.brightness     <= 3'd7;
            cfg_reg.ticks_per_unit <= 8'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BRIGHTNESS: cfg_reg.brightness     <= cfg_wdata[2:0];
                CFG_TICKS:      cfg_reg.ticks_per_unit <= cfg_wdata;
                default:        cfg_reg                <= cfg_reg;
            endcase
        end
    end

    svsw_front #(
        .DIGITS (DIGITS)
    ) u_front (
        .tuser (s_tuser),
        .tdata (s_tdata),
        .item  (front_item)
    );

    svsw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (front_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    svsw_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== rtl/core/svsw_checker.sv =====
// Port-level checks for the serial writer, bound to the top level.
// Depends on seven_segment_serial_writer_unit_assert.svh.
`include "seven_segment_serial_writer_unit_assert.svh"

module svsw_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // input side only backs up behind a held result
    `SVSW_ASSERT_NOW(a_stall_source, !s_tready, m_tvalid)
    `SVSW_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // released data line reads high
    `SVSW_ASSERT_NOW(a_release_high, m_tvalid && !m_tdata[2], m_tdata[1])
    `SVSW_ASSERT_NOW(a_accept_busy, m_tvalid && m_tdata[4], m_tdata[3])

endmodule

bind seven_segment_serial_writer_unit svsw_checker u_svsw_checker (.*);
